// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge out of reset
`define CTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cta_pkg.sv -----
package cta_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [31:0] ENTRY_RESET = 32'h0000_FFFE;
    localparam logic [31:0] HEAP_OFFSET = 32'(TABLE_ENTRIES * 4);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_data;
    } t_tbl_req;

endpackage

// ----- rtl/cta_if.sv -----
interface cta_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] request_size;
    logic [31:0] free_address;

    modport source (output valid, operation, request_size, free_address, input ready);
    modport sink (input valid, operation, request_size, free_address, output ready);
endinterface

interface cta_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic        success;
    logic [31:0] alloc_total;
    logic [31:0] free_total;

    modport source (output valid, result_address, success, alloc_total, free_total,
                    input ready);
    modport sink (input valid, result_address, success, alloc_total, free_total,
                  output ready);
endinterface

interface cta_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] section_start;

    modport source (output valid, section_start, input ready);
    modport sink (input valid, section_start, output ready);
endinterface

// ----- rtl/chunk_table_allocator_top.sv -----
// word to result: request registered, k entries (1 to 64) scanned, result stored
// throughput: one word per scan, each entry read through the single table read port
// the next word is taken once the result has moved into the output register
// reset: counters zero, every table entry reads 0x0000FFFE, heap base 256 (section 0)
// no clearing pass: per-entry valid bits are cleared at once
`include "assert_macros.svh"

module chunk_table_allocator_top
    import cta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cta_req_if.sink   i_req,
    cta_rsp_if.source o_rsp,
    cta_cfg_if.sink   i_cfg
);

    logic [31:0] r_heap_base;
    logic [31:0] n_heap_base;
    t_tbl_req    tbl_req;
    logic [31:0] tbl_rd_data;

    // base is the rounded-up section start past the table words
    assign n_heap_base = ((i_cfg.section_start + 32'd3) & ~32'd3) + HEAP_OFFSET;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= HEAP_OFFSET;
        end else if (i_cfg.valid) begin
            r_heap_base <= n_heap_base;
        end
    end

    cta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_heap_base (r_heap_base),
        .o_tbl       (tbl_req),
        .i_rd_data   (tbl_rd_data)
    );

    cta_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd_data)
    );

    `CTA_ASSERT(a_base_aligned, i_clk, i_rst_n,
        r_heap_base[1:0] == 2'b00, "heap base not word aligned")
    `CTA_ASSERT(a_fail_zero, i_clk, i_rst_n,
        o_rsp.valid && !o_rsp.success |-> o_rsp.result_address == 32'd0,
        "failed result carries an address")
    `CTA_ASSERT(a_one_at_a_time, i_clk, i_rst_n,
        i_req.valid && i_req.ready |=> !i_req.ready, "second word taken during a scan")
    `CTA_ASSERT(a_write_busy, i_clk, i_rst_n,
        tbl_req.wr_en |-> !i_req.ready, "table written while idle")

endmodule

// ----- rtl/cta_table.sv -----
module cta_table
    import cta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tbl_req    i_req,
    output logic [31:0] o_rd_data
);

    logic [31:0]              r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries never written read as the reset word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : ENTRY_RESET;

endmodule

// ----- rtl/cta_ctrl.sv -----
module cta_ctrl
    import cta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cta_req_if.sink     i_req,
    cta_rsp_if.source   o_rsp,
    input  logic [31:0] i_heap_base,
    output t_tbl_req    o_tbl,
    input  logic [31:0] i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [31:0]      r_want, n_want;
    logic [31:0]      r_key, n_key;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    logic             r_ev_vld, n_ev_vld;
    logic [15:0]      r_running, n_running;
    logic [15:0]      r_hit_off, n_hit_off;
    logic             r_ok, n_ok;
    logic [31:0]      r_alloc_cnt, n_alloc_cnt;
    logic [31:0]      r_free_cnt, n_free_cnt;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_addr, n_out_addr;
    logic             r_out_ok, n_out_ok;
    logic [31:0]      r_out_alloc, n_out_alloc;
    logic [31:0]      r_out_free, n_out_free;

    logic        issue;
    logic [15:0] e_off;
    logic [31:0] e_size;
    logic        e_occ;

    assign e_off  = i_rd_data[31:16];
    assign e_size = {17'd0, i_rd_data[15:1]};
    assign e_occ  = i_rd_data[0];
    assign issue  = (r_state == S_SCAN) && (r_rd_idx < CNT_W'(TABLE_ENTRIES));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_want      = r_want;
        n_key       = r_key;
        n_rd_idx    = r_rd_idx;
        n_ev_idx    = r_ev_idx;
        n_ev_vld    = r_ev_vld;
        n_running   = r_running;
        n_hit_off   = r_hit_off;
        n_ok        = r_ok;
        n_alloc_cnt = r_alloc_cnt;
        n_free_cnt  = r_free_cnt;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        n_out_addr  = r_out_addr;
        n_out_ok    = r_out_ok;
        n_out_alloc = r_out_alloc;
        n_out_free  = r_out_free;

        o_tbl.rd_en   = issue;
        o_tbl.rd_addr = r_rd_idx[IDX_W-1:0];
        o_tbl.wr_en   = 1'b0;
        o_tbl.wr_addr = r_ev_idx;
        o_tbl.wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.operation;
                    n_want    = (i_req.request_size + 32'd3) & ~32'd3;
                    n_key     = i_req.free_address - i_heap_base;
                    n_rd_idx  = '0;
                    n_ev_vld  = 1'b0;
                    n_running = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of the next entry overlaps the check of this one
                n_ev_vld = issue;
                n_ev_idx = r_rd_idx[IDX_W-1:0];
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_ev_vld) begin
                    if (r_op == OP_FREE) begin
                        if ({16'd0, e_off} == r_key) begin
                            o_tbl.wr_en   = 1'b1;
                            o_tbl.wr_data = {i_rd_data[31:1], 1'b0};
                            n_free_cnt    = r_free_cnt + 32'd1;
                            n_ok          = 1'b1;
                            n_state       = S_DONE;
                        end else if (r_ev_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    end else begin
                        if (!e_occ && e_off != 16'd0 && e_size == r_want) begin
                            // exact-size reuse keeps the stored offset
                            o_tbl.wr_en   = 1'b1;
                            o_tbl.wr_data = {i_rd_data[31:1], 1'b1};
                            n_hit_off     = e_off;
                            n_alloc_cnt   = r_alloc_cnt + 32'd1;
                            n_ok          = 1'b1;
                            n_state       = S_DONE;
                        end else if (!e_occ && e_size >= r_want) begin
                            o_tbl.wr_en   = 1'b1;
                            o_tbl.wr_data = {r_running, r_want[14:0], 1'b1};
                            n_hit_off     = r_running;
                            n_alloc_cnt   = r_alloc_cnt + 32'd1;
                            n_ok          = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_running = r_running + e_size[15:0];
                            if (r_ev_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                                n_ok    = 1'b0;
                                n_state = S_DONE;
                            end
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = (r_ok && r_op == OP_ALLOC)
                                ? i_heap_base + {16'd0, r_hit_off} : 32'd0;
                    n_out_ok    = r_ok;
                    n_out_alloc = r_alloc_cnt;
                    n_out_free  = r_free_cnt;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ev_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ev_vld    <= n_ev_vld;
            r_rd_idx    <= n_rd_idx;
            r_alloc_cnt <= n_alloc_cnt;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_want      <= n_want;
        r_key       <= n_key;
        r_ev_idx    <= n_ev_idx;
        r_running   <= n_running;
        r_hit_off   <= n_hit_off;
        r_ok        <= n_ok;
        r_out_addr  <= n_out_addr;
        r_out_ok    <= n_out_ok;
        r_out_alloc <= n_out_alloc;
        r_out_free  <= n_out_free;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.success        = r_out_ok;
    assign o_rsp.alloc_total    = r_out_alloc;
    assign o_rsp.free_total     = r_out_free;

endmodule
